// ===== src/u2u_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
// No dependencies; imported by every module of the block.
package u2u_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STRAY    = 3'd1,
    ST_BAD_LEAD = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_RANGE    = 3'd4,
    ST_SURR     = 3'd5
  } status_t;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam logic [20:0] CP_MAX      = 21'h10ffff;
  localparam logic [20:0] CP_SUPP     = 21'h010000;
  localparam logic [20:0] CP_SURR_LO  = 21'h00d800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00dfff;
  localparam logic [20:0] CP_MIN_2B   = 21'h000080;
  localparam logic [20:0] CP_MIN_3B   = 21'h000800;
  localparam logic [15:0] HI_SURR_TAG = 16'hd800;
  localparam logic [15:0] LO_SURR_TAG = 16'hdc00;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        last_of_run;
    logic        string_done;
    status_t     status;
    logic [31:0] fail_offset;
    logic [31:0] unit_count;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== src/u2u_dec.sv =====
// Input register and per-byte decode: sequence state, error latch, unit count.
// Depends on u2u_pkg; pushes zero, one or two results per byte to the queue.
module u2u_dec #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_stall,
  input  logic [7:0]      in_byte,
  input  logic            room,
  output u2u_pkg::push_t  push
);
  import u2u_pkg::*;

  logic                    held;
  logic [7:0]              hold_byte;
  logic [1:0]              pend, pend_next;
  logic [20:0]             cp, cp_next;
  logic [1:0]              cls, cls_next;
  logic [OFFSET_WIDTH-1:0] pos, pos_next;
  logic [OFFSET_WIDTH-1:0] start, start_next;
  logic [31:0]             units, units_next;
  status_t                 err, err_next;
  logic [OFFSET_WIDTH-1:0] eoff, eoff_next;

  logic                    adv;
  logic [20:0]             cp_acc;
  logic [20:0]             cp_min;
  logic [20:0]             cp_off;
  logic [32:0]             sum1, sum2;
  logic [31:0]             units_p1, units_p2;
  status_t                 term_st;
  logic [OFFSET_WIDTH-1:0] term_off;

  assign adv        = held && room;
  assign byte_stall = held && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      held <= 1'b1;
    end else if (adv) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      hold_byte <= in_byte;
    end
  end

  assign cp_acc   = {cp[14:0], hold_byte[5:0]};
  assign cp_off   = cp_acc - CP_SUPP;
  assign sum1     = {1'b0, units} + 33'd1;
  assign sum2     = {1'b0, units} + 33'd2;
  assign units_p1 = sum1[32] ? '1 : sum1[31:0];
  assign units_p2 = sum2[32] ? '1 : sum2[31:0];

  always_comb begin
    case (cls)
      2'd1:    cp_min = CP_MIN_2B;
      2'd2:    cp_min = CP_MIN_3B;
      default: cp_min = CP_SUPP;
    endcase
  end

  always_comb begin
    if (err == ST_OK && pend != 2'd0) begin
      term_st  = ST_TRUNC;
      term_off = start;
    end else begin
      term_st  = err;
      term_off = (err != ST_OK) ? eoff : '0;
    end
  end

  always_comb begin
    pend_next  = pend;
    cp_next    = cp;
    cls_next   = cls;
    pos_next   = pos;
    start_next = start;
    units_next = units;
    err_next   = err;
    eoff_next  = eoff;
    push       = '0;
    if (adv) begin
      if (hold_byte == 8'h00) begin
        push.n                 = 2'd1;
        push.r0.last_of_run    = 1'b1;
        push.r0.string_done    = 1'b1;
        push.r0.status         = term_st;
        push.r0.fail_offset    = 32'(term_off);
        push.r0.unit_count     = units;
        pend_next  = '0;
        cp_next    = '0;
        cls_next   = '0;
        pos_next   = '0;
        start_next = '0;
        units_next = '0;
        err_next   = ST_OK;
        eoff_next  = '0;
      end else begin
        if (!(&pos)) begin
          pos_next = pos + OFFSET_WIDTH'(1);
        end
        if (err == ST_OK) begin
          if (pend == 2'd0) begin
            start_next = pos;
            if (hold_byte inside {[8'h01:8'h7f]}) begin
              push.n              = 2'd1;
              push.r0.code_unit   = {8'h00, hold_byte};
              push.r0.unit_valid  = 1'b1;
              push.r0.last_of_run = 1'b1;
              units_next          = units_p1;
            end else if (hold_byte inside {[8'h80:8'hbf]}) begin
              err_next  = ST_STRAY;
              eoff_next = pos;
            end else if (hold_byte inside {[8'hc0:8'hdf]}) begin
              cp_next   = {16'd0, hold_byte[4:0]};
              cls_next  = 2'd1;
              pend_next = 2'd1;
            end else if (hold_byte inside {[8'he0:8'hef]}) begin
              cp_next   = {17'd0, hold_byte[3:0]};
              cls_next  = 2'd2;
              pend_next = 2'd2;
            end else if (hold_byte inside {[8'hf0:8'hf7]}) begin
              cp_next   = {18'd0, hold_byte[2:0]};
              cls_next  = 2'd3;
              pend_next = 2'd3;
            end else begin
              err_next  = ST_BAD_LEAD;
              eoff_next = pos;
            end
          end else if (hold_byte[7:6] != 2'b10) begin
            err_next  = ST_TRUNC;
            eoff_next = start;
            pend_next = '0;
          end else begin
            cp_next   = cp_acc;
            pend_next = pend - 2'd1;
            if (pend == 2'd1) begin
              if (cp_acc < cp_min) begin
                err_next  = ST_BAD_LEAD;
                eoff_next = start;
              end else if (cp_acc > CP_MAX) begin
                err_next  = ST_RANGE;
                eoff_next = start;
              end else if (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI) begin
                err_next  = ST_SURR;
                eoff_next = start;
              end else if (cp_acc >= CP_SUPP) begin
                push.n              = 2'd2;
                push.r0.code_unit   = HI_SURR_TAG | {6'd0, cp_off[19:10]};
                push.r0.unit_valid  = 1'b1;
                push.r1.code_unit   = LO_SURR_TAG | {6'd0, cp_off[9:0]};
                push.r1.unit_valid  = 1'b1;
                push.r1.last_of_run = 1'b1;
                units_next          = units_p2;
              end else begin
                push.n              = 2'd1;
                push.r0.code_unit   = cp_acc[15:0];
                push.r0.unit_valid  = 1'b1;
                push.r0.last_of_run = 1'b1;
                units_next          = units_p1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= '0;
      cp    <= '0;
      cls   <= '0;
      pos   <= '0;
      start <= '0;
      units <= '0;
      err   <= ST_OK;
      eoff  <= '0;
    end else begin
      pend  <= pend_next;
      cp    <= cp_next;
      cls   <= cls_next;
      pos   <= pos_next;
      start <= start_next;
      units <= units_next;
      err   <= err_next;
      eoff  <= eoff_next;
    end
  end

  a_pair_shape: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> push.r0.unit_valid && !push.r0.last_of_run && push.r1.last_of_run)
    else $error("surrogate pair pushed with wrong framing");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    adv && hold_byte == 8'h00 |=> pend == 2'd0 && err == ST_OK && units == 32'd0)
    else $error("terminator did not clear string state");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err != ST_OK && !(adv && hold_byte == 8'h00) |=> $stable(err) && $stable(units))
    else $error("latched error or count changed before terminator");

endmodule

// ===== src/u2u_resq.sv =====
// Result queue: takes up to two results a cycle, hands out one a cycle unless res_stall holds it.
// Depends on u2u_pkg; decouples the decoder from result-side stalls.
module u2u_resq (
  input  logic             clk,
  input  logic             rst,
  input  u2u_pkg::push_t   push,
  output logic             room,
  output logic             res_valid,
  input  logic             res_stall,
  output u2u_pkg::result_t head
);
  import u2u_pkg::*;

  result_t               entries [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   rd_ptr, wr_ptr;
  logic [RQ_CNT_W-1:0]   count;
  logic                  pop;

  assign res_valid = count != '0;
  assign pop       = res_valid && !res_stall;
  assign room      = count <= RQ_CNT_W'(RQ_DEPTH - 2);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      entries[wr_ptr + RQ_PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_PTR_W'(push.n);
      rd_ptr <= rd_ptr + RQ_PTR_W'(pop);
      count  <= count + RQ_CNT_W'(push.n) - RQ_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> room)
    else $error("result pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue count out of range");

endmodule

// ===== src/utf8_to_utf16_stream_decoder.sv =====
// Top level of the UTF-8 to UTF-16 stream decoder.
// Depends on u2u_pkg, u2u_dec and u2u_resq.
// Takes one UTF-8 byte per cycle (0 ends a string) and streams UTF-16 units: one
// result per completed BMP codepoint, two (high then low surrogate) above U+FFFF,
// and one done result per terminator carrying status, error offset and unit count.
// Bytes after the first error of a string give no results before its terminator;
// discard the string when the done status is non-zero. A byte is held in the input
// register on acceptance and decoded once the queue has room, its results being
// registered into the queue; the block sustains one byte per cycle and pauses
// input only while its four-entry result queue holds more than two results.
module utf8_to_utf16_stream_decoder #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  in_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] code_unit,
  output logic        unit_valid,
  output logic        last_of_run,
  output logic        string_done,
  output logic [2:0]  status,
  output logic [31:0] fail_offset,
  output logic [31:0] unit_count
);
  import u2u_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  u2u_dec #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_dec (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .in_byte   (in_byte),
    .room      (room),
    .push      (push)
  );

  u2u_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .head     (head)
  );

  assign code_unit    = head.code_unit;
  assign unit_valid   = head.unit_valid;
  assign last_of_run  = head.last_of_run;
  assign string_done  = head.string_done;
  assign status       = head.status;
  assign fail_offset  = head.fail_offset;
  assign unit_count   = head.unit_count;

endmodule
